// ===== src/pps_pkg.sv =====
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    // Saturating count of jobs that still have work: none, one, more than one.
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_ONE  = 2'd1;
    localparam logic [1:0] ACT_MANY = 2'd2;

    // Best candidate so far, handed from cell to cell during a sweep.
    typedef struct packed {
        logic        found;
        logic [7:0]  prio;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remain;
        logic [7:0]  label;
        logic [1:0]  active;
    } tok_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic        wr_en;
        logic        dec_en;
        logic [7:0]  label;
        logic [7:0]  prio;
        logic [15:0] arrival;
        logic [15:0] burst;
    } cmd_t;

endpackage

// ===== src/preemptive_priority_scheduler.sv =====
// Top level: preemptive priority scheduler built as a chain of job-slot cells.
// A load request writes the next free slot. For a tick request the candidate
// passes one cell per cycle down the chain, then the pick is applied and the
// statistics are formed before the result enters the output register.
// Reset (asynchronous, active low) empties the table, clears time and count.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int JOBS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  job_label,
    input  logic [7:0]  priority_req,
    input  logic [15:0] arrival,
    input  logic [15:0] burst,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] tick_start,
    output logic        idle,
    output logic [7:0]  run_label,
    output logic        finished,
    output logic [31:0] completion_time,
    output logic [31:0] turnaround,
    output logic [31:0] waiting,
    output logic        all_done
);

    localparam int IDX_W = (JOBS > 1) ? $clog2(JOBS) : 1;
    localparam int CNT_W = $clog2(JOBS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_APPLY,
        ST_FINAL
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] sweep_cnt_reg;
    logic [31:0]      time_reg;
    logic [CNT_W-1:0] jobs_reg;

    // Pick captured at the end of the sweep.
    logic             pick_found_reg;
    logic             pick_fin_reg;
    logic [7:0]       pick_label_reg;
    logic [15:0]      pick_burst_reg;
    logic [31:0]      start_reg;
    logic [31:0]      end_reg;
    logic [31:0]      tat_reg;
    logic             done_reg;

    // Output register; it parts the result from the next request.
    logic             out_valid_reg;
    logic [31:0]      out_start_reg;
    logic             out_idle_reg;
    logic [7:0]       out_label_reg;
    logic             out_fin_reg;
    logic [31:0]      out_ct_reg;
    logic [31:0]      out_tat_reg;
    logic [31:0]      out_wt_reg;
    logic             out_done_reg;

    cmd_t             cmd;
    logic [IDX_W-1:0] cmd_idx;
    tok_t             chain [JOBS+1];
    logic [IDX_W-1:0] chain_idx [JOBS+1];

    logic             accept;
    logic             load_ok;
    tok_t             best;
    logic             best_fin;
    logic [31:0]      end_time;
    logic             out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign load_ok  = accept && (kind == KIND_LOAD) &&
                      (jobs_reg < CNT_W'(JOBS)) && (burst != 16'd0);
    assign out_free = !out_valid_reg || !out_stall;

    assign best     = chain[JOBS];
    assign best_fin = best.found && (best.remain == 16'd1);
    assign end_time = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + 32'd1;

    // Writes go to the next free slot; the decrement goes to the picked slot.
    always_comb
    begin
        cmd.wr_en   = load_ok;
        cmd.dec_en  = (state_reg == ST_APPLY) && best.found;
        cmd.label   = job_label;
        cmd.prio    = priority_req;
        cmd.arrival = arrival;
        cmd.burst   = burst;
        if (state_reg == ST_APPLY)
        begin
            cmd_idx = chain_idx[JOBS];
        end
        else
        begin
            cmd_idx = jobs_reg[IDX_W-1:0];
        end
    end

    // The head of the chain always sees an empty candidate, so the tail holds
    // the winner once the token has run through every cell.
    assign chain[0]     = '0;
    assign chain_idx[0] = '0;

    for (genvar g = 0; g < JOBS; g++)
    begin : g_cell
        pps_cell #(
            .IDX_W   (IDX_W),
            .CELL_ID (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .cmd_idx    (cmd_idx),
            .start_time (time_reg),
            .tok_in     (chain[g]),
            .idx_in     (chain_idx[g]),
            .tok_out    (chain[g+1]),
            .idx_out    (chain_idx[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sweep_cnt_reg <= '0;
            time_reg      <= '0;
            jobs_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new result is presented once the output register is free;
            // otherwise a taken result leaves the register empty.
            if ((state_reg == ST_FINAL) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (load_ok)
                    begin
                        jobs_reg <= jobs_reg + CNT_W'(1);
                    end
                    if (accept && (kind == KIND_TICK))
                    begin
                        sweep_cnt_reg <= '0;
                        state_reg     <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + IDX_W'(1);
                    if (sweep_cnt_reg == IDX_W'(JOBS - 1))
                    begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    time_reg  <= end_time;
                    state_reg <= ST_FINAL;
                end
                ST_FINAL:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Statistics path: the wide subtract against arrival happens while the
    // pick is applied, the compare and subtract against burst as the output is loaded.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_APPLY)
        begin
            pick_found_reg <= best.found;
            pick_fin_reg   <= best_fin;
            pick_label_reg <= best.label;
            pick_burst_reg <= best.burst;
            start_reg      <= time_reg;
            end_reg        <= end_time;
            tat_reg        <= end_time - {16'd0, best.arrival};
            done_reg       <= (best.active == ACT_NONE) ||
                              ((best.active == ACT_ONE) && best_fin);
        end
        if ((state_reg == ST_FINAL) && out_free)
        begin
            out_start_reg <= start_reg;
            out_idle_reg  <= !pick_found_reg;
            out_label_reg <= pick_found_reg ? pick_label_reg : 8'd0;
            out_fin_reg   <= pick_fin_reg;
            out_ct_reg    <= pick_fin_reg ? end_reg : 32'd0;
            out_tat_reg   <= pick_fin_reg ? tat_reg : 32'd0;
            // Saturated time can leave turnaround below the burst.
            if (pick_fin_reg && (tat_reg >= {16'd0, pick_burst_reg}))
            begin
                out_wt_reg <= tat_reg - {16'd0, pick_burst_reg};
            end
            else
            begin
                out_wt_reg <= 32'd0;
            end
            out_done_reg  <= done_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign tick_start      = out_start_reg;
    assign idle            = out_idle_reg;
    assign run_label       = out_label_reg;
    assign finished        = out_fin_reg;
    assign completion_time = out_ct_reg;
    assign turnaround      = out_tat_reg;
    assign waiting         = out_wt_reg;
    assign all_done        = out_done_reg;

endmodule

// ===== src/pps_cell.sv =====
// One job slot of the scheduler chain, with its stage of the candidate sweep.
module pps_cell
    import pps_pkg::*;
#(
    parameter int IDX_W   = 4,
    parameter int CELL_ID = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic [IDX_W-1:0] cmd_idx,
    input  logic [31:0]      start_time,
    input  tok_t             tok_in,
    input  logic [IDX_W-1:0] idx_in,
    output tok_t             tok_out,
    output logic [IDX_W-1:0] idx_out
);

    logic             used_reg;
    logic [7:0]       prio_reg;
    logic [15:0]      arrival_reg;
    logic [15:0]      burst_reg;
    logic [15:0]      remain_reg;
    logic [7:0]       label_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             hit;
    logic             active;
    logic             eligible;
    logic             take;

    assign hit      = (cmd_idx == IDX_W'(CELL_ID));
    assign active   = used_reg && (remain_reg != 16'd0);
    assign eligible = active && ({16'd0, arrival_reg} <= start_time);

    // The earlier slot keeps a full tie, so this slot must be strictly better.
    assign take = eligible && (!tok_in.found || (prio_reg < tok_in.prio) ||
                  ((prio_reg == tok_in.prio) && (arrival_reg < tok_in.arrival)));

    always_comb
    begin
        tok_next = tok_in;
        idx_next = idx_in;
        if (take)
        begin
            tok_next.found   = 1'b1;
            tok_next.prio    = prio_reg;
            tok_next.arrival = arrival_reg;
            tok_next.burst   = burst_reg;
            tok_next.remain  = remain_reg;
            tok_next.label   = label_reg;
            idx_next         = IDX_W'(CELL_ID);
        end
        if (active)
        begin
            tok_next.active = (tok_in.active == ACT_NONE) ? ACT_ONE : ACT_MANY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (cmd.wr_en && hit)
        begin
            used_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && hit)
        begin
            prio_reg    <= cmd.prio;
            arrival_reg <= cmd.arrival;
            burst_reg   <= cmd.burst;
            remain_reg  <= cmd.burst;
            label_reg   <= cmd.label;
        end
        else if (cmd.dec_en && hit)
        begin
            remain_reg <= remain_reg - 16'd1;
        end
        tok_reg <= tok_next;
        idx_reg <= idx_next;
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule
